// File: rtl/core/dee_pkg.sv
// Shared types, codes and constants for the document-identifier escape encoder.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package dee_pkg;

    // Default text limit; at most MAX_TEXT_DEF-1 characters leave per stream
    localparam int unsigned MAX_TEXT_DEF = 512;
    // Default depth of the queue between front end and back end (power of two)
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned LEN_W = 31;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned DIGIT_IDX_W = 4;
    localparam int unsigned PROD_W = 63;
    localparam int unsigned QUOT_LSB = 35;

    // Multiply by this and shift right by QUOT_LSB to divide by ten
    localparam logic [DATA_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_EQUAL = 8'h3D;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHR_PRINT_HI = 8'h7E;
    localparam logic [7:0] MAX_TYPE = 8'd9;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_CHARS = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    // One queued command: start carries the length in data[30:0], chars carry
    // up to four characters first-out in data[31:24], end carries the status
    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] data;
        logic [2:0]        count;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHARS,
        BK_END,
        BK_MUL,
        BK_FIX,
        BK_DIGITS,
        BK_COLON
    } back_state_t;

    // Powers of ten used to count the decimal digits of a length
    function automatic logic [LEN_W-1:0] pow10(input logic [3:0] k);
        logic [LEN_W-1:0] p;
        unique case (k)
            4'd1:    p = 31'd10;
            4'd2:    p = 31'd100;
            4'd3:    p = 31'd1000;
            4'd4:    p = 31'd10000;
            4'd5:    p = 31'd100000;
            4'd6:    p = 31'd1000000;
            4'd7:    p = 31'd10000000;
            4'd8:    p = 31'd100000000;
            4'd9:    p = 31'd1000000000;
            default: p = 31'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CHR_ZERO + {4'd0, nib};
        end else begin
            c = 8'h41 + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

// File: rtl/core/dee_front.sv
// Front end: accepts items, tracks record phase, text count and sticky status,
// and queues a command per start, end or character-yielding item. Depends on dee_pkg.
`timescale 1ns / 1ps

module dee_front import dee_pkg::*; #(
    parameter int unsigned MAX_TEXT = MAX_TEXT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic [LEN_W-1:0] s_doc_length,
    input  logic [7:0]       s_id_byte,
    output logic             push,
    output cmd_t             push_cmd,
    input  logic             q_full
);

    localparam int unsigned CW = $clog2(MAX_TEXT);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_TEXT - 1);

    phase_t        phase_reg, phase_next;
    logic [7:0]    bytes_left_reg, bytes_left_next;
    logic [CW-1:0] chars_out_reg, chars_out_next;
    status_t       sticky_reg, sticky_next;

    logic          accept;
    logic [3:0]    ndig;
    logic [7:0]    ch [4];
    logic [2:0]    n_chars;
    logic [2:0]    n_emit;
    logic [CW-1:0] avail;
    logic [7:0]    left_dec;
    status_t       end_status;

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;

    // Count decimal digits of the start length
    always_comb begin
        ndig = 4'd1;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (s_doc_length >= pow10(4'(k))) begin
                ndig = ndig + 4'd1;
            end
        end
    end

    assign avail = LIMIT - chars_out_reg;
    assign left_dec = bytes_left_reg - 8'd1;
    assign end_status = (sticky_reg == ST_OK && phase_reg != PH_TYPE) ? ST_TRUNC : sticky_reg;

    // Classify the item and work out its characters
    always_comb begin
        phase_next = phase_reg;
        bytes_left_next = bytes_left_reg;
        chars_out_next = chars_out_reg;
        sticky_next = sticky_reg;
        push = 1'b0;
        push_cmd = '{kind: CMD_CHARS, data: '0, count: 3'd0};
        ch[0] = 8'd0;
        ch[1] = 8'd0;
        ch[2] = 8'd0;
        ch[3] = 8'd0;
        n_chars = 3'd0;
        n_emit = 3'd0;

        if (accept) begin
            unique case (opcode_t'(s_opcode))
                OP_START: begin
                    phase_next = PH_TYPE;
                    bytes_left_next = 8'd0;
                    sticky_next = ST_OK;
                    chars_out_next = CW'(ndig) + CW'(1);
                    push = 1'b1;
                    push_cmd = '{kind: CMD_START, data: {1'b0, s_doc_length}, count: 3'd0};
                end
                OP_BYTE: begin
                    if (sticky_reg == ST_OK) begin
                        unique case (phase_reg)
                            PH_TYPE: begin
                                if (s_id_byte > MAX_TYPE) begin
                                    sticky_next = ST_BAD_TYPE;
                                end else begin
                                    ch[0] = CHR_ZERO + s_id_byte;
                                    ch[1] = CHR_EQUAL;
                                    n_chars = 3'd2;
                                    phase_next = PH_LEN;
                                end
                            end
                            PH_LEN: begin
                                bytes_left_next = s_id_byte;
                                if (s_id_byte == 8'd0) begin
                                    ch[0] = CHR_SEMI;
                                    n_chars = 3'd1;
                                    phase_next = PH_TYPE;
                                end else begin
                                    phase_next = PH_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (s_id_byte >= CHR_PRINT_LO && s_id_byte <= CHR_PRINT_HI) begin
                                    ch[0] = s_id_byte;
                                    ch[1] = CHR_SEMI;
                                    n_chars = 3'd1;
                                end else begin
                                    ch[0] = CHR_PERCENT;
                                    ch[1] = hex_char(s_id_byte[7:4]);
                                    ch[2] = hex_char(s_id_byte[3:0]);
                                    ch[3] = CHR_SEMI;
                                    n_chars = 3'd3;
                                end
                                bytes_left_next = left_dec;
                                if (left_dec == 8'd0) begin
                                    n_chars = n_chars + 3'd1;
                                    phase_next = PH_TYPE;
                                end
                            end
                            default: begin
                                phase_next = PH_TYPE;
                            end
                        endcase

                        // Clip to the text limit, flag overflow
                        if (CW'(n_chars) > avail) begin
                            n_emit = avail[2:0];
                            sticky_next = ST_OVERFLOW;
                        end else begin
                            n_emit = n_chars;
                        end
                        chars_out_next = chars_out_reg + CW'(n_emit);
                        push = (n_emit != 3'd0);
                        push_cmd = '{kind: CMD_CHARS, data: {ch[0], ch[1], ch[2], ch[3]},
                                     count: n_emit};
                    end
                end
                OP_END: begin
                    push = 1'b1;
                    push_cmd = '{kind: CMD_END, data: {30'd0, end_status}, count: 3'd0};
                    phase_next = PH_TYPE;
                    bytes_left_next = 8'd0;
                    chars_out_next = '0;
                    sticky_next = ST_OK;
                end
                OP_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            bytes_left_reg <= 8'd0;
            chars_out_reg <= '0;
            sticky_reg <= ST_OK;
        end else begin
            phase_reg <= phase_next;
            bytes_left_reg <= bytes_left_next;
            chars_out_reg <= chars_out_next;
            sticky_reg <= sticky_next;
        end
    end

endmodule

// File: rtl/core/dee_queue.sv
// Short command queue between front end and back end.
// Depends on dee_pkg for the command type.
`timescale 1ns / 1ps

module dee_queue import dee_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next = count_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/dee_back.sv
// Back end: pops commands, converts start lengths to decimal, and drives the
// result output register one character per transfer. Depends on dee_pkg.
`timescale 1ns / 1ps

module dee_back import dee_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_is_last,
    output logic [1:0] m_status
);

    back_state_t             state_reg, state_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    logic [2:0]              left_reg, left_next;
    logic [PROD_W-1:0]       prod_reg;
    logic [DIGIT_IDX_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]              digit_buffer_reg [NUM_DIGITS];
    logic                    m_valid_reg, m_valid_next;
    logic [7:0]              m_out_char_reg, m_out_char_next;
    logic                    m_is_last_reg, m_is_last_next;
    logic [1:0]              m_status_reg, m_status_next;

    logic                    out_free;
    logic [LEN_W-1:0]        quot;
    logic [LEN_W-1:0]        rem;
    logic [3:0]              digit;
    logic                    digit_we;
    logic [DIGIT_IDX_W-1:0]  rd_idx;

    assign out_free = !m_valid_reg || m_ready;

    // Divide by ten from the registered product
    assign quot = LEN_W'(prod_reg[PROD_W-1:QUOT_LSB]);
    assign rem = data_reg[LEN_W-1:0] - ((quot << 3) + (quot << 1));
    assign digit = rem[3:0];
    assign rd_idx = cnt_reg - DIGIT_IDX_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    unique case (q_head.kind)
                        CMD_START: state_next = BK_MUL;
                        CMD_CHARS: state_next = BK_CHARS;
                        CMD_END:   state_next = BK_END;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_CHARS: begin
                if (out_free && left_reg == 3'd1) begin
                    state_next = BK_IDLE;
                end
            end
            BK_END: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            BK_MUL: state_next = BK_FIX;
            BK_FIX: state_next = (quot == '0) ? BK_DIGITS : BK_MUL;
            BK_DIGITS: begin
                if (out_free && cnt_reg == DIGIT_IDX_W'(1)) begin
                    state_next = BK_COLON;
                end
            end
            BK_COLON: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and output register loads
    always_comb begin
        q_pop = 1'b0;
        data_next = data_reg;
        left_next = left_reg;
        cnt_next = cnt_reg;
        digit_we = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_out_char_next = m_out_char_reg;
        m_is_last_next = m_is_last_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    data_next = q_head.data;
                    left_next = q_head.count;
                    cnt_next = '0;
                end
            end
            BK_CHARS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_out_char_next = data_reg[DATA_W-1 -: 8];
                    m_is_last_next = 1'b0;
                    m_status_next = ST_OK;
                    data_next = data_reg << 8;
                    left_next = left_reg - 3'd1;
                end
            end
            BK_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_out_char_next = 8'd0;
                    m_is_last_next = 1'b1;
                    m_status_next = data_reg[1:0];
                end
            end
            BK_MUL: begin
            end
            BK_FIX: begin
                digit_we = 1'b1;
                cnt_next = cnt_reg + DIGIT_IDX_W'(1);
                data_next = {1'b0, quot};
            end
            BK_DIGITS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_out_char_next = CHR_ZERO + {4'd0, digit_buffer_reg[rd_idx]};
                    m_is_last_next = 1'b0;
                    m_status_next = ST_OK;
                    cnt_next = rd_idx;
                end
            end
            BK_COLON: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_out_char_next = CHR_COLON;
                    m_is_last_next = 1'b0;
                    m_status_next = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers, multiplier stage and digit store
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        left_reg <= left_next;
        cnt_reg <= cnt_next;
        m_out_char_reg <= m_out_char_next;
        m_is_last_reg <= m_is_last_next;
        m_status_reg <= m_status_next;
        prod_reg <= PROD_W'(data_reg[LEN_W-1:0] * RECIP_TEN);
        if (digit_we) begin
            digit_buffer_reg[cnt_reg] <= digit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_is_last = m_is_last_reg;
    assign m_status = m_status_reg;

endmodule

// File: rtl/core/docid_escape_encoder.sv
// Top level of the document-identifier escape encoder.
// Depends on dee_pkg, dee_front, dee_queue and dee_back.
`timescale 1ns / 1ps

// Items yield their characters on the m_ channel one per cycle while m_ready
// is high. The front end takes one item per cycle while the command queue has
// room; the back end picks up each command in its idle state before sending
// its characters. An identifier byte that yields no characters never reaches
// the queue, and an end item gives one output with m_is_last set and the status.
// A start item is converted to decimal by a shared multiply-by-reciprocal
// unit with a multiply step and a fix step per digit. The output register
// decouples the result side, so output stalls stall the back end and reach
// the front end only once the command queue is full.

module docid_escape_encoder import dee_pkg::*; #(
    parameter int unsigned MAX_TEXT = MAX_TEXT_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic [LEN_W-1:0] s_doc_length,
    input  logic [7:0]       s_id_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_is_last,
    output logic [1:0]       m_status
);

    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;
    logic q_pop;
    cmd_t q_head;
    logic q_empty;

    dee_front #(
        .MAX_TEXT(MAX_TEXT)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_doc_length(s_doc_length),
        .s_id_byte(s_id_byte),
        .push(q_push),
        .push_cmd(q_push_cmd),
        .q_full(q_full)
    );

    dee_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_cmd(q_push_cmd),
        .full(q_full),
        .pop(q_pop),
        .head(q_head),
        .empty(q_empty)
    );

    dee_back u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_head(q_head),
        .q_pop(q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_char(m_out_char),
        .m_is_last(m_is_last),
        .m_status(m_status)
    );

    // Never push into a full queue
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Never pop an empty queue
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // An accepted end item always lands in the queue
    a_end_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_END) |=> !q_empty)
        else $error("end item lost");

endmodule
